/* rtl/sup_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sup_pkg
// Types, constants and the GSM default alphabet lookup of the septet packer.
// ----------------------------------------------------------------------------
package sup_pkg;

  // coding modes of the configuration register
  localparam logic [1:0] MODE_GSM7 = 2'd0;
  localparam logic [1:0] MODE_8BIT = 2'd1;
  localparam logic [1:0] MODE_UCS2 = 2'd2;

  // length limits per message
  localparam logic [8:0] LIMIT_GSM7 = 9'd160;
  localparam logic [7:0] LIMIT_8BIT = 8'd140;
  localparam logic [7:0] LIMIT_UCS2 = 8'd70;

  // special septets
  localparam logic [6:0] ESC_SEPTET   = 7'h1B;
  localparam logic [6:0] QMARK_SEPTET = 7'h3F;

  // octets one item can produce
  localparam int unsigned MAX_OCTETS = 3;

  // pending bits plus two septets
  localparam int unsigned ACCW = 21;

  typedef enum logic [1:0] {
    MAP_BASIC,
    MAP_EXT,
    MAP_MISS
  } map_kind_t;

  typedef struct packed {
    map_kind_t  kind;
    logic [6:0] code;
  } lookup_t;

  // all octets produced by one item
  typedef struct packed {
    logic [MAX_OCTETS-1:0][7:0] oct;
    logic [1:0]                 num;
    logic                       eom;
    logic                       miss;
  } group_t;

  // reverse map of a byte into the default alphabet or the extension table
  function automatic lookup_t gsm_lookup(input logic [7:0] b);
    lookup_t r;
    r.kind = MAP_BASIC;
    r.code = b[6:0];
    unique case (b)
      8'h40: r.code = 7'd0;
      8'hA3: r.code = 7'd1;
      8'h24: r.code = 7'd2;
      8'hA5: r.code = 7'd3;
      8'hE8: r.code = 7'd4;
      8'hE9: r.code = 7'd5;
      8'hF9: r.code = 7'd6;
      8'hEC: r.code = 7'd7;
      8'hF2: r.code = 7'd8;
      8'hC7: r.code = 7'd9;
      8'h0A: r.code = 7'd10;
      8'hD8: r.code = 7'd11;
      8'hF8: r.code = 7'd12;
      8'h0D: r.code = 7'd13;
      8'hC5: r.code = 7'd14;
      8'hE5: r.code = 7'd15;
      8'h5F: r.code = 7'd17;
      8'hC6: r.code = 7'd28;
      8'hE6: r.code = 7'd29;
      8'hDF: r.code = 7'd30;
      8'hC9: r.code = 7'd31;
      8'hA4: r.code = 7'd36;
      8'hA1: r.code = 7'd64;
      8'hC4: r.code = 7'd91;
      8'hD6: r.code = 7'd92;
      8'hD1: r.code = 7'd93;
      8'hDC: r.code = 7'd94;
      8'hA7: r.code = 7'd95;
      8'hBF: r.code = 7'd96;
      8'hE4: r.code = 7'd123;
      8'hF6: r.code = 7'd124;
      8'hF1: r.code = 7'd125;
      8'hFC: r.code = 7'd126;
      8'hE0: r.code = 7'd127;
      8'h5E: begin r.kind = MAP_EXT; r.code = 7'h14; end
      8'h7B: begin r.kind = MAP_EXT; r.code = 7'h28; end
      8'h7D: begin r.kind = MAP_EXT; r.code = 7'h29; end
      8'h5C: begin r.kind = MAP_EXT; r.code = 7'h2F; end
      8'h5B: begin r.kind = MAP_EXT; r.code = 7'h3C; end
      8'h7E: begin r.kind = MAP_EXT; r.code = 7'h3D; end
      8'h5D: begin r.kind = MAP_EXT; r.code = 7'h3E; end
      8'h7C: begin r.kind = MAP_EXT; r.code = 7'h40; end
      default: begin
        // ascii ranges that keep their code
        if (!((b >= 8'h20 && b <= 8'h23) || (b >= 8'h25 && b <= 8'h3F) ||
              (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
          r.kind = MAP_MISS;
          r.code = QMARK_SEPTET;
        end
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/sup_encode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sup_encode
// Per-item encoder: maps, packs and limits one character combinationally
// and holds the mode register and the message state.
// ----------------------------------------------------------------------------
module sup_encode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_data,
  input  wire logic            accept,
  input  wire logic [7:0]      char_byte,
  input  wire logic            end_of_message,
  output logic                 push,
  output sup_pkg::group_t      group
);
  import sup_pkg::*;

  logic [1:0] coding_mode;
  logic [6:0] pending_bits, pending_bits_next;
  logic [2:0] pending_count, pending_count_next;
  logic [7:0] char_count, char_count_next;

  lookup_t         lk;
  logic            is_ext;
  logic [1:0]      cnt;
  logic [6:0]      s0;
  logic [8:0]      cc_sum;
  logic [3:0]      sh1;
  logic [ACCW-1:0] acc;
  logic [4:0]      total;
  logic [ACCW-1:0] acc_rest;
  group_t          g;

  // septets of the character
  always_comb begin
    lk     = gsm_lookup(char_byte);
    is_ext = (lk.kind == MAP_EXT);
    cnt    = is_ext ? 2'd2 : 2'd1;
    s0     = is_ext ? ESC_SEPTET : lk.code;
    cc_sum = {1'b0, char_count} + {7'b0, cnt};
  end

  // pack septets behind the pending bits
  always_comb begin
    sh1   = {1'b0, pending_count} + 4'd7;
    acc   = ACCW'(pending_bits) | (ACCW'(s0) << pending_count) |
            (is_ext ? (ACCW'(lk.code) << sh1) : '0);
    total = {2'b0, pending_count} + (is_ext ? 5'd14 : 5'd7);
    acc_rest = acc >> {total[4:3], 3'b000};
  end

  // result group and next state
  always_comb begin
    g                  = '0;
    g.eom              = end_of_message;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    char_count_next    = char_count;
    unique case (coding_mode)
      MODE_GSM7: begin
        if (cc_sum <= LIMIT_GSM7) begin
          g.oct[0]           = acc[7:0];
          g.oct[1]           = acc[15:8];
          g.num              = total[4:3];
          g.miss             = (lk.kind == MAP_MISS);
          pending_bits_next  = acc_rest[6:0];
          pending_count_next = total[2:0];
          char_count_next    = cc_sum[7:0];
        end
      end
      MODE_8BIT: begin
        if (char_count < LIMIT_8BIT) begin
          g.oct[0]        = char_byte;
          g.num           = 2'd1;
          char_count_next = char_count + 8'd1;
        end
      end
      MODE_UCS2: begin
        if (char_count < LIMIT_UCS2) begin
          g.oct[0]        = 8'h00;
          g.oct[1]        = char_byte;
          g.num           = 2'd2;
          char_count_next = char_count + 8'd1;
        end
      end
      default: begin
        // invalid mode emits nothing
      end
    endcase

    // flush residual bits at end of message
    if (end_of_message) begin
      if (pending_count_next != 3'd0) begin
        g.oct[g.num] = {1'b0, pending_bits_next};
        g.num        = g.num + 2'd1;
      end
      pending_bits_next  = '0;
      pending_count_next = '0;
      char_count_next    = '0;
    end
  end

  assign push  = accept && (g.num != 2'd0);
  assign group = g;

  // mode register and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode   <= MODE_GSM7;
      pending_bits  <= '0;
      pending_count <= '0;
      char_count    <= '0;
    end else begin
      if (cfg_we) begin
        coding_mode <= cfg_data;
      end
      if (accept) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
        char_count    <= char_count_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/sup_group_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sup_group_fifo
// Two-entry queue of result groups that hands out the octets of each group one
// by one on the output stream.
// ----------------------------------------------------------------------------
module sup_group_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sup_pkg::group_t group,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           octet,
  output logic                 last_octet,
  output logic                 unmapped
);
  import sup_pkg::*;

  group_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] idx;

  group_t head;
  logic   head_end;
  logic   pop;

  // head of the queue
  always_comb begin
    head       = entries[rd_ptr];
    head_end   = (idx == head.num - 2'd1);
    out_valid  = (count != 2'd0);
    octet      = head.oct[idx];
    last_octet = head.eom && head_end;
    unmapped   = head.miss;
    pop        = out_valid && out_ready && head_end;
    in_ready   = (count != 2'd2);
  end

  // group storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= group;
    end
  end

  // pointers, fill count and octet index
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= '0;
      end else if (out_valid && out_ready) begin
        idx <= idx + 2'd1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* rtl/sms_user_data_septet_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sms_user_data_septet_packer
// SMS user-data encoder: GSM 7-bit packing, 8-bit pass-through or UCS2.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata char_byte, tlast end_of_message
// m_axis    out  m_axis_tvalid/m_axis_tready tdata octet, tlast last_octet,
//                                            tuser unmapped
// cfg       in   cfg_valid/cfg_ready         cfg_data coding_mode
//
// An item is encoded in the cycle it is accepted; its zero to three octets go
// into a two-entry group queue and come out one per cycle while m_axis_tready is
// high. Input is taken every cycle while the queue has a free entry, so with no
// output stall the rate is one item per cycle if each item yields at most one octet.
// cfg_ready is always high. Reset clears the mode to GSM 7-bit and the state.
// ----------------------------------------------------------------------------
module sms_user_data_septet_packer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] octet
  output logic            m_axis_tlast,
  output logic            m_axis_tuser    // [0] unmapped
);
  import sup_pkg::*;

  logic   accept;
  logic   push;
  group_t group;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // character encoder
  sup_encode u_encode (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .char_byte      (s_axis_tdata),
    .end_of_message (s_axis_tlast),
    .push           (push),
    .group          (group)
  );

  // result queue and octet serializer
  sup_group_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .group      (group),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .octet      (m_axis_tdata),
    .last_octet (m_axis_tlast),
    .unmapped   (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* rtl/sup_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sup_checker
// Port-level checks of the septet packer, bound to the top level.
// ----------------------------------------------------------------------------
module sup_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tuser
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled output item changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // empty queue always takes input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output side empty");

  // no output without an accepted input item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !$past(m_axis_tvalid) && !$past(s_axis_tvalid && s_axis_tready) |->
      !m_axis_tvalid)
    else $error("output item appeared without input");

endmodule

bind sms_user_data_septet_packer sup_checker u_sup_checker (.*);
`default_nettype wire
